// ===== hw/rtl/mep_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
package mep_pkg;

    localparam int DEF_COORD_BITS = 10;
    localparam int FRAC_BITS      = 28;
    localparam int CNT_W          = 8;
    localparam int GREY_W         = 5;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [64:0] wide_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REAL_START = 3'd0,
        CFG_IMAG_TOP   = 3'd1,
        CFG_REAL_STEP  = 3'd2,
        CFG_IMAG_STEP  = 3'd3,
        CFG_MAX_ITER   = 3'd4
    } cfg_idx_t;

    localparam fix_t             RST_REAL_START = -32'sd536870912;
    localparam fix_t             RST_IMAG_TOP   = 32'sd281857229;
    localparam fix_t             RST_REAL_STEP  = 32'sd1007893;
    localparam fix_t             RST_IMAG_STEP  = 32'sd1008313;
    localparam logic [CNT_W-1:0] RST_MAX_ITER   = 8'd30;

    localparam logic [CNT_W-1:0]  GREY_FULL_CNT = 8'd20;
    localparam logic [GREY_W-1:0] GREY_FULL     = 5'd20;

    // |z|^2 escape bound, 4.0 in the working format
    localparam wide_t ESC_LIMIT = wide_t'(4) <<< FRAC_BITS;

    localparam wide_t WIDE_S32_MAX = 65'sd2147483647;
    localparam wide_t WIDE_S32_MIN = -65'sd2147483648;

    typedef struct packed {
        logic load;         // capture pixel coordinate
        logic map_mul;      // coordinate times step
        logic map_add;      // form c, seed z = c, clear count
        logic mul;          // square and cross products of z
        logic step;         // z = z^2 + c, count++
        logic mark_inside;  // ran out of iterations
        logic mark_escape;  // |z|^2 > 4 at current count
    } dp_cmd_t;

    typedef struct packed {
        logic limit_hit;    // count reached max_iterations
        logic escaped;      // |z|^2 > 4 from current products
    } dp_stat_t;

    function automatic fix_t sat32(input wide_t v);
        fix_t r;
        if (v > WIDE_S32_MAX)
            r = WIDE_S32_MAX[31:0];
        else if (v < WIDE_S32_MIN)
            r = WIDE_S32_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/mep_dp.sv =====
// Datapath: point mapping, z iteration, escape test and result fields.
module mep_dp
    import mep_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  fix_t                  real_start,
    input  fix_t                  imag_top,
    input  fix_t                  real_step,
    input  fix_t                  imag_step,
    input  logic [CNT_W-1:0]      max_iterations,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y,
    output logic                  res_inside,
    output logic [CNT_W-1:0]      res_count,
    output logic [GREY_W-1:0]     res_grey
);

    localparam int MW = COORD_BITS + 33;

    logic [COORD_BITS-1:0]  px_reg, py_reg;
    logic signed [MW-1:0]   mr_reg, mi_reg;
    fix_t                   cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [63:0]     prr_reg, pii_reg, pri_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   inside_reg;

    logic signed [63:0]     r2, i2, xprod;
    wide_t                  mag;
    fix_t                   cr_next, ci_next, zr_next, zi_next;

    always_comb
    begin
        r2      = prr_reg >>> FRAC_BITS;
        i2      = pii_reg >>> FRAC_BITS;
        xprod   = pri_reg >>> (FRAC_BITS - 1);
        mag     = wide_t'(r2) + wide_t'(i2);
        zr_next = sat32(wide_t'(r2) - wide_t'(i2) + wide_t'(cr_reg));
        zi_next = sat32(wide_t'(xprod) + wide_t'(ci_reg));
        cr_next = sat32(wide_t'(real_start) + wide_t'(mr_reg));
        ci_next = sat32(wide_t'(imag_top) - wide_t'(mi_reg));
    end

    assign stat.limit_hit = (n_reg >= max_iterations);
    assign stat.escaped   = (mag > ESC_LIMIT);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map_mul)
        begin
            mr_reg <= $signed({1'b0, px_reg}) * real_step;
            mi_reg <= $signed({1'b0, py_reg}) * imag_step;
        end
        if (cmd.map_add)
        begin
            cr_reg <= cr_next;
            ci_reg <= ci_next;
            zr_reg <= cr_next;
            zi_reg <= ci_next;
            n_reg  <= '0;
        end
        if (cmd.mul)
        begin
            prr_reg <= zr_reg * zr_reg;
            pii_reg <= zi_reg * zi_reg;
            pri_reg <= zr_reg * zi_reg;
        end
        if (cmd.step)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
            n_reg  <= n_reg + 1'b1;
        end
        if (cmd.mark_inside)
            inside_reg <= 1'b1;
        else if (cmd.mark_escape)
            inside_reg <= 1'b0;
    end

    assign res_x      = px_reg;
    assign res_y      = py_reg;
    assign res_inside = inside_reg;
    assign res_count  = inside_reg ? '0 : n_reg;
    assign res_grey   = (inside_reg || n_reg >= GREY_FULL_CNT) ? '0
                      : GREY_FULL - GREY_W'(n_reg);

    a_seed_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.map_add |=> (n_reg == '0))
        else $error("count not cleared after seeding z");

endmodule

// ===== hw/rtl/mep_ctrl.sv =====
// Controller: sequences mapping, iteration and result hand-off.
module mep_ctrl
    import mep_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    output logic     emit,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_ITER_MUL,
        ST_ITER_TEST,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = ST_MAP_ADD;
            end
            ST_MAP_ADD:
            begin
                cmd.map_add = 1'b1;
                state_next  = ST_ITER_MUL;
            end
            ST_ITER_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.limit_hit)
                begin
                    cmd.mark_inside = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                    state_next = ST_ITER_TEST;
            end
            ST_ITER_TEST:
            begin
                if (stat.escaped)
                begin
                    cmd.mark_escape = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_ITER_MUL;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_step_loops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> cmd.mul)
        else $error("iteration step not followed by product stage");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready while an item is in flight");

endmodule

// ===== hw/rtl/mandelbrot_escape_pixel.sv =====
// Top level: Mandelbrot escape-time evaluator for one pixel per item.
// Each item is mapped, then iterated through the product/test loop: an escaping item leaves
// the loop at its count n, and an inside point leaves when the count reaches max_iterations.
// Throughput: one item at a time, and the product/test loop sets the rate. A finished item
// waits until the output register is free, and the next item is taken in the idle state after that.
// Reset (rst_n, async low) clears control and loads the default view registers.
module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input item stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,   // pixel_x, pixel_y
    // result item stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*COORD_BITS+CNT_W+GREY_W+8)/8)*8-1:0] m_tdata,
        // out_x, out_y, inside_res, escape_count, grey_level
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [CFG_ADDR_W-1:0]                cfg_addr,
    input  logic [CFG_DATA_W-1:0]                cfg_wdata
);

    localparam int OUT_W = ((2*COORD_BITS+CNT_W+GREY_W+8)/8)*8;

    // view and limit registers
    fix_t             real_start_reg, imag_top_reg, real_step_reg, imag_step_reg;
    logic [CNT_W-1:0] max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_start_reg <= RST_REAL_START;
            imag_top_reg   <= RST_IMAG_TOP;
            real_step_reg  <= RST_REAL_STEP;
            imag_step_reg  <= RST_IMAG_STEP;
            max_iter_reg   <= RST_MAX_ITER;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_REAL_START: real_start_reg <= cfg_wdata;
                CFG_IMAG_TOP:   imag_top_reg   <= cfg_wdata;
                CFG_REAL_STEP:  real_step_reg  <= cfg_wdata;
                CFG_IMAG_STEP:  imag_step_reg  <= cfg_wdata;
                CFG_MAX_ITER:   max_iter_reg   <= cfg_wdata[CNT_W-1:0];
                default:        ; // unused index, write dropped
            endcase
        end
    end

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     emit;
    logic     out_free;

    logic [COORD_BITS-1:0] res_x, res_y;
    logic                  res_inside;
    logic [CNT_W-1:0]      res_count;
    logic [GREY_W-1:0]     res_grey;

    mep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .emit     (emit),
        .cmd      (cmd),
        .stat     (stat)
    );

    mep_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .pixel_x        (s_tdata[COORD_BITS-1:0]),
        .pixel_y        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .real_start     (real_start_reg),
        .imag_top       (imag_top_reg),
        .real_step      (real_step_reg),
        .imag_step      (imag_step_reg),
        .max_iterations (max_iter_reg),
        .res_x          (res_x),
        .res_y          (res_y),
        .res_inside     (res_inside),
        .res_count      (res_count),
        .res_grey       (res_grey)
    );

    // Output register: holds a finished item so the core can take the next one.
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({res_grey, res_count, res_inside, res_y, res_x});
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("finished item did not reach the output register");

endmodule
